/* hw/rtl/bpfc_pkg.sv */
// ----------------------------------------------------------------------------
// bpfc_pkg
// Shared types and constants of the BMP pixel format converter.
// ----------------------------------------------------------------------------
package bpfc_pkg;

    localparam int COLOR_W     = 32;
    localparam int SHIFT_W     = 5;
    localparam int FORMAT_W    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int PAL_INDEX_W = 8;

    localparam logic [FORMAT_W-1:0] FMT_PALETTE8   = 3'd0;
    localparam logic [FORMAT_W-1:0] FMT_RAW16      = 3'd1;
    localparam logic [FORMAT_W-1:0] FMT_RAW24      = 3'd2;
    localparam logic [FORMAT_W-1:0] FMT_RAW32      = 3'd3;
    localparam logic [FORMAT_W-1:0] FMT_BITFIELDS  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_MASK        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_MASK      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_MASK       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MASK      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT_KEY = 3'd5;

    localparam logic ACT_CONVERT = 1'b0;
    localparam logic ACT_PALETTE = 1'b1;

    localparam logic [COLOR_W-1:0] RED_MASK_RESET   = 32'h00FF_0000;
    localparam logic [COLOR_W-1:0] GREEN_MASK_RESET = 32'h0000_FF00;
    localparam logic [COLOR_W-1:0] BLUE_MASK_RESET  = 32'h0000_00FF;
    localparam logic [COLOR_W-1:0] ALPHA_MASK_RESET = 32'hFF00_0000;

    typedef struct packed {
        logic                   action;
        logic                   first_pixel;
        logic [COLOR_W-1:0]     pixel_word;
        logic [PAL_INDEX_W-1:0] palette_index;
        logic [COLOR_W-1:0]     palette_value;
    } in_word_t;

    typedef struct packed {
        logic               pixel_write;
        logic               color_load;
        logic [COLOR_W-1:0] draw_color;
    } out_word_t;

    typedef struct packed {
        logic [FORMAT_W-1:0] pixel_format;
        logic [COLOR_W-1:0]  red_mask;
        logic [COLOR_W-1:0]  green_mask;
        logic [COLOR_W-1:0]  blue_mask;
        logic [COLOR_W-1:0]  alpha_mask;
        logic [SHIFT_W-1:0]  red_shift;
        logic [SHIFT_W-1:0]  green_shift;
        logic [SHIFT_W-1:0]  blue_shift;
        logic [SHIFT_W-1:0]  alpha_shift;
        logic [COLOR_W-1:0]  transparent_key;
    } cfg_t;

    function automatic logic [SHIFT_W-1:0] trailing_zeros(input logic [COLOR_W-1:0] m);
        logic [SHIFT_W-1:0] n;
        n = '0;
        for (int i = COLOR_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                n = SHIFT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

/* hw/rtl/bpfc_ram.sv */
// ----------------------------------------------------------------------------
// bpfc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bpfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/bpfc_cfg.sv */
// ----------------------------------------------------------------------------
// bpfc_cfg
// Configuration registers, with channel shifts derived when a mask is written.
// ----------------------------------------------------------------------------
module bpfc_cfg
    import bpfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]     cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT:
                begin
                    cfg_next.pixel_format = cfg_data[FORMAT_W-1:0];
                end
                REG_RED_MASK:
                begin
                    cfg_next.red_mask  = cfg_data;
                    cfg_next.red_shift = trailing_zeros(cfg_data);
                end
                REG_GREEN_MASK:
                begin
                    cfg_next.green_mask  = cfg_data;
                    cfg_next.green_shift = trailing_zeros(cfg_data);
                end
                REG_BLUE_MASK:
                begin
                    cfg_next.blue_mask  = cfg_data;
                    cfg_next.blue_shift = trailing_zeros(cfg_data);
                end
                REG_ALPHA_MASK:
                begin
                    cfg_next.alpha_mask  = cfg_data;
                    cfg_next.alpha_shift = trailing_zeros(cfg_data);
                end
                REG_TRANSPARENT_KEY:
                begin
                    cfg_next.transparent_key = cfg_data;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format    <= FMT_PALETTE8;
            cfg_reg.red_mask        <= RED_MASK_RESET;
            cfg_reg.green_mask      <= GREEN_MASK_RESET;
            cfg_reg.blue_mask       <= BLUE_MASK_RESET;
            cfg_reg.alpha_mask      <= ALPHA_MASK_RESET;
            cfg_reg.red_shift       <= trailing_zeros(RED_MASK_RESET);
            cfg_reg.green_shift     <= trailing_zeros(GREEN_MASK_RESET);
            cfg_reg.blue_shift      <= trailing_zeros(BLUE_MASK_RESET);
            cfg_reg.alpha_shift     <= trailing_zeros(ALPHA_MASK_RESET);
            cfg_reg.transparent_key <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/bpfc_convert.sv */
// ----------------------------------------------------------------------------
// bpfc_convert
// Per-pixel conversion: format decode, transparency and color-change flags.
// ----------------------------------------------------------------------------
module bpfc_convert
    import bpfc_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [COLOR_W-1:0] pixel_word,
    input  logic               first_pixel,
    input  logic               index_in_range,
    input  logic [COLOR_W-1:0] palette_color,
    input  logic [COLOR_W-1:0] last_color,
    output out_word_t          result,
    output logic [COLOR_W-1:0] key
);

    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
    logic [COLOR_W-1:0] bitfield_color;
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] prev_color;
    logic               write;

    assign red   = (pixel_word & cfg.red_mask) >> cfg.red_shift;
    assign green = (pixel_word & cfg.green_mask) >> cfg.green_shift;
    assign blue  = (pixel_word & cfg.blue_mask) >> cfg.blue_shift;
    assign alpha = (pixel_word & cfg.alpha_mask) >> cfg.alpha_shift;

    // The negated alpha (256 minus alpha) wraps at 8 bits, so only the low byte of alpha matters.
    assign bitfield_color = {8'(8'd0 - alpha[7:0]), 24'd0}
                          | (red << 16) | (green << 8) | blue;

    always_comb
    begin
        unique case (cfg.pixel_format)
            FMT_PALETTE8:
            begin
                color = index_in_range ? palette_color : '0;
                key   = {24'd0, pixel_word[7:0]};
            end
            FMT_RAW16:
            begin
                color = {16'd0, pixel_word[15:0]};
                key   = color;
            end
            FMT_RAW24:
            begin
                color = {8'd0, pixel_word[23:0]};
                key   = color;
            end
            FMT_BITFIELDS:
            begin
                color = bitfield_color;
                key   = color;
            end
            default:
            begin
                color = pixel_word;
                key   = color;
            end
        endcase
    end

    assign prev_color = first_pixel ? '0 : last_color;
    assign write      = (key != cfg.transparent_key);

    assign result.pixel_write = write;
    assign result.color_load  = write && (key != prev_color);
    assign result.draw_color  = color;

endmodule

/* hw/rtl/bmp_pixel_format_converter.sv */
// ----------------------------------------------------------------------------
// bmp_pixel_format_converter
// Converts stored BMP pixel words into 32-bit draw colors.
// ----------------------------------------------------------------------------
// Items arrive on the in channel (valid/ready). A palette item writes one
// palette entry and yields nothing; a convert item yields one word on the out
// channel with the draw color and the write and color-load flags.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must do so only while no item is in flight, which the block does
// not enforce. A convert item passes the first stage, which holds it while
// the palette RAM read completes, then the output stage, which holds the
// result. Throughput is one item per cycle while out_ready stays high.
// Reset clears the pipeline, the last color and the registers to their
// defaults. Palette contents are undefined until written.
// When out_ready is low the result holds, the first stage fills, and then
// in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module bmp_pixel_format_converter
    import bpfc_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]     cfg_data
);

    localparam int PAL_ADDR_W = $clog2(PALETTE_DEPTH);

    cfg_t               cfg;
    logic               s1_advance;
    logic               accept;
    logic               pixel_accept;
    logic               palette_write;
    logic [COLOR_W-1:0] palette_color;
    out_word_t          conv_result;
    logic [COLOR_W-1:0] conv_key;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_first_reg;
    logic [COLOR_W-1:0] s1_word_reg;
    logic               s1_in_range_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_word_t          out_data_reg;
    logic [COLOR_W-1:0] last_color_reg;
    logic [COLOR_W-1:0] last_color_next;

    bpfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s1_advance    = !out_valid_reg || out_ready;
    assign in_ready      = !s1_valid_reg || s1_advance;
    assign accept        = in_valid && in_ready;
    assign pixel_accept  = accept && (in_data.action == ACT_CONVERT);
    assign palette_write = accept && (in_data.action == ACT_PALETTE)
                        && (32'(in_data.palette_index) < PALETTE_DEPTH);

    bpfc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (palette_write),
        .wr_addr (in_data.palette_index[PAL_ADDR_W-1:0]),
        .wr_data (in_data.palette_value),
        .rd_en   (pixel_accept),
        .rd_addr (in_data.pixel_word[PAL_ADDR_W-1:0]),
        .rd_data (palette_color)
    );

    bpfc_convert u_convert (
        .cfg            (cfg),
        .pixel_word     (s1_word_reg),
        .first_pixel    (s1_first_reg),
        .index_in_range (s1_in_range_reg),
        .palette_color  (palette_color),
        .last_color     (last_color_reg),
        .result         (conv_result),
        .key            (conv_key)
    );

    always_comb
    begin
        s1_valid_next   = in_ready ? pixel_accept : s1_valid_reg;
        out_valid_next  = s1_advance ? s1_valid_reg : out_valid_reg;
        last_color_next = last_color_reg;
        if (s1_advance && s1_valid_reg)
        begin
            priority if (conv_result.color_load)
            begin
                last_color_next = conv_key;
            end
            else if (s1_first_reg)
            begin
                last_color_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_color_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            last_color_reg <= last_color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_first_reg    <= in_data.first_pixel;
            s1_word_reg     <= in_data.pixel_word;
            s1_in_range_reg <= (32'(in_data.pixel_word[7:0]) < PALETTE_DEPTH);
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg <= conv_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// BMP pixel format converter testbench
// Drives palette writes and pixel conversions through every pixel format and
// through many register settings. A predictor in the testbench tracks the
// palette, the registers and the last loaded color, and builds the result
// word that each accepted pixel must produce. Both handshakes idle and stall
// at random, and a long output stall is held while pixels are sent back to back.
// ----------------------------------------------------------------------------
module testbench
    import bpfc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_word_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_word_t              out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]     cfg_data;

    logic [FORMAT_W-1:0] pred_format;
    logic [COLOR_W-1:0]  mask_red;
    logic [COLOR_W-1:0]  mask_green;
    logic [COLOR_W-1:0]  mask_blue;
    logic [COLOR_W-1:0]  mask_alpha;
    logic [COLOR_W-1:0]  key_value;
    logic [COLOR_W-1:0]  last_loaded;
    logic [COLOR_W-1:0]  palette_mem [256];
    bit                  palette_set [256];

    out_word_t pending_colors [$];
    out_word_t want;
    int        errors = 0;
    bit        gaps_on = 1'b1;
    int        hold_request = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    bmp_pixel_format_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [COLOR_W-1:0] mask_field(input logic [COLOR_W-1:0] word,
                                                      input logic [COLOR_W-1:0] mask);
        int sh;
        sh = 0;
        if (mask != '0)
        begin
            while (!mask[sh])
            begin
                sh++;
            end
        end
        return (word & mask) >> sh;
    endfunction

    function automatic void convert_pixel(input logic [COLOR_W-1:0] word,
                                          output logic [COLOR_W-1:0] color,
                                          output logic [COLOR_W-1:0] cmp);
        logic [COLOR_W-1:0] alpha;
        case (pred_format)
            FMT_PALETTE8:
            begin
                color = palette_mem[word[7:0]];
                cmp   = {24'd0, word[7:0]};
            end
            FMT_RAW16:
            begin
                color = {16'd0, word[15:0]};
                cmp   = color;
            end
            FMT_RAW24:
            begin
                color = {8'd0, word[23:0]};
                cmp   = color;
            end
            FMT_BITFIELDS:
            begin
                alpha = mask_field(word, mask_alpha);
                color = ((32'd256 - alpha) << 24)
                      | (mask_field(word, mask_red) << 16)
                      | (mask_field(word, mask_green) << 8)
                      | mask_field(word, mask_blue);
                cmp   = color;
            end
            default:
            begin
                color = word;
                cmp   = color;
            end
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] compare_value(input logic [COLOR_W-1:0] word);
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] cmp;
        convert_pixel(word, color, cmp);
        return cmp;
    endfunction

    function automatic void predict_word(input in_word_t w);
        out_word_t          r;
        logic [COLOR_W-1:0] cmp;
        if (w.action == ACT_PALETTE)
        begin
            palette_mem[w.palette_index] = w.palette_value;
            palette_set[w.palette_index] = 1'b1;
            return;
        end
        if (w.first_pixel)
        begin
            last_loaded = '0;
        end
        convert_pixel(w.pixel_word, r.draw_color, cmp);
        r.pixel_write = (cmp != key_value);
        r.color_load  = r.pixel_write && (cmp != last_loaded);
        if (r.color_load)
        begin
            last_loaded = cmp;
        end
        pending_colors.push_back(r);
    endfunction

    function automatic logic [COLOR_W-1:0] rand_mask();
        logic [63:0] ones;
        int          w;
        int          p;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2:
            begin
                w    = $urandom_range(1, 32);
                p    = $urandom_range(0, 32 - w);
                ones = (64'd1 << w) - 64'd1;
                return 32'(ones << p);
            end
            3: return $urandom;
            4: return 32'd1 << $urandom_range(0, 31);
            default: return 32'hFF << (8 * $urandom_range(0, 3));
        endcase
    endfunction

    task automatic send_word(input in_word_t w);
        while (gaps_on && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_word(w);
    endtask

    task automatic send_pixel(input logic first, input logic [COLOR_W-1:0] word);
        in_word_t w;
        w.action        = ACT_CONVERT;
        w.first_pixel   = first;
        w.pixel_word    = word;
        w.palette_index = PAL_INDEX_W'($urandom);
        w.palette_value = $urandom;
        send_word(w);
    endtask

    task automatic send_palette(input logic [PAL_INDEX_W-1:0] idx,
                                input logic [COLOR_W-1:0] val);
        in_word_t w;
        w.action        = ACT_PALETTE;
        w.first_pixel   = 1'($urandom);
        w.pixel_word    = $urandom;
        w.palette_index = idx;
        w.palette_value = val;
        send_word(w);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_colors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_PIXEL_FORMAT:    pred_format = val[FORMAT_W-1:0];
            REG_RED_MASK:        mask_red    = val;
            REG_GREEN_MASK:      mask_green  = val;
            REG_BLUE_MASK:       mask_blue   = val;
            REG_ALPHA_MASK:      mask_alpha  = val;
            REG_TRANSPARENT_KEY: key_value   = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_setup(input logic [FORMAT_W-1:0] fmt,
                                 input logic [COLOR_W-1:0] red,
                                 input logic [COLOR_W-1:0] green,
                                 input logic [COLOR_W-1:0] blue,
                                 input logic [COLOR_W-1:0] alpha,
                                 input logic [COLOR_W-1:0] key);
        drain_results();
        write_reg(REG_PIXEL_FORMAT, {{(COLOR_W-FORMAT_W){1'b0}}, fmt});
        write_reg(REG_RED_MASK, red);
        write_reg(REG_GREEN_MASK, green);
        write_reg(REG_BLUE_MASK, blue);
        write_reg(REG_ALPHA_MASK, alpha);
        write_reg(REG_TRANSPARENT_KEY, key);
        end_writes();
    endtask

    task automatic test_directed();
        send_palette(8'h00, 32'hFFFF_FFFF);
        send_palette(8'hFF, 32'h0000_0000);
        send_palette(8'h5A, $urandom);
        send_pixel(1'b1, 32'hFFFF_FF00);
        send_pixel(1'b0, 32'h0000_00FF);
        send_pixel(1'b0, 32'h1234_56FF);
        send_pixel(1'b0, 32'h0000_005A);
        send_palette(8'h5A, $urandom);
        send_pixel(1'b0, 32'hABCD_EF5A);

        program_setup(FMT_RAW16, RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET,
                      ALPHA_MASK_RESET, 32'h0000_0000);
        send_pixel(1'b0, 32'hFFFF_0000);
        send_pixel(1'b1, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'h0000_FFFF);

        program_setup(FMT_RAW24, RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET,
                      ALPHA_MASK_RESET, 32'h00FF_FFFF);
        send_pixel(1'b0, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'h0000_0000);

        program_setup(FMT_RAW32, '0, '0, '0, '0, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'h8000_0001);

        program_setup(3'd7, '1, '1, '1, '1, 32'h0000_0000);
        send_pixel(1'b0, 32'hDEAD_BEEF);
        program_setup(3'd5, '1, '1, '1, '1, 32'h0000_0000);
        send_pixel(1'b0, 32'h0000_0000);

        program_setup(FMT_BITFIELDS, RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET,
                      ALPHA_MASK_RESET, 32'h0000_0000);
        send_pixel(1'b1, 32'h0000_0000);
        send_pixel(1'b0, 32'hFF12_3456);

        program_setup(FMT_BITFIELDS, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                      32'h0000_0001, 32'h0000_0000);
        send_pixel(1'b0, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'h8000_0000);
    endtask

    task automatic test_palette_load();
        for (int i = 0; i < 256; i++)
        begin
            send_palette(PAL_INDEX_W'(i), $urandom);
        end
    endtask

    task automatic test_backpressure();
        logic [COLOR_W-1:0] pool [4];
        program_setup(FMT_PALETTE8, RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET,
                      ALPHA_MASK_RESET, 32'h0000_0007);
        foreach (pool[i])
        begin
            pool[i] = $urandom;
        end
        gaps_on = 1'b0;
        hold_request = 100;
        for (int i = 0; i < 40; i++)
        begin
            send_pixel($urandom_range(0, 9) == 0, pool[$urandom_range(0, 3)]);
        end
        drain_results();
        gaps_on = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            send_pixel($urandom_range(0, 9) == 0, $urandom);
        end
    endtask

    task automatic test_random_streams();
        logic [FORMAT_W-1:0]    fmt;
        logic [COLOR_W-1:0]     pool [4];
        logic [COLOR_W-1:0]     word;
        logic [PAL_INDEX_W-1:0] idx;
        bit                     follow;
        int                     r;
        for (int p = 0; p < 18; p++)
        begin
            gaps_on = (p != 5) && (p != 6);
            fmt = (p % 2 == 1) ? FMT_BITFIELDS : FORMAT_W'((p / 2) % 8);
            program_setup(fmt, rand_mask(), rand_mask(), rand_mask(), rand_mask(), $urandom);
            foreach (pool[i])
            begin
                pool[i] = $urandom;
            end
            if ($urandom_range(0, 9) < 6)
            begin
                write_reg(REG_TRANSPARENT_KEY, compare_value(pool[0]));
                end_writes();
            end
            follow = 1'b0;
            idx    = '0;
            for (int i = 0; i < 55; i++)
            begin
                r = $urandom_range(0, 99);
                if (!follow && r < 8)
                begin
                    idx = PAL_INDEX_W'($urandom);
                    send_palette(idx, $urandom);
                    follow = (pred_format == FMT_PALETTE8) && ($urandom_range(0, 1) == 1);
                end
                else
                begin
                    if (follow)
                    begin
                        word = {24'($urandom_range(0, 24'hFF_FFFF)), idx};
                    end
                    else if (r < 50)
                    begin
                        word = pool[$urandom_range(0, 3)];
                    end
                    else
                    begin
                        word = $urandom;
                    end
                    while (pred_format == FMT_PALETTE8 && !palette_set[word[7:0]])
                    begin
                        word[7:0] = 8'($urandom);
                    end
                    follow = 1'b0;
                    send_pixel($urandom_range(0, 19) == 0, word);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_left = hold_request;
            hold_seen = hold_request;
        end
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= !(gaps_on && $urandom_range(0, 99) < 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $realtime, out_data);
                errors++;
            end
            else
            begin
                want = pending_colors.pop_front();
                if (out_data.pixel_write !== want.pixel_write)
                begin
                    $display("%0t: pixel_write expected %b actual %b",
                             $realtime, want.pixel_write, out_data.pixel_write);
                    errors++;
                end
                if (out_data.color_load !== want.color_load)
                begin
                    $display("%0t: color_load expected %b actual %b",
                             $realtime, want.color_load, out_data.color_load);
                    errors++;
                end
                if (out_data.draw_color !== want.draw_color)
                begin
                    $display("%0t: draw_color expected %h actual %h",
                             $realtime, want.draw_color, out_data.draw_color);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("[bmp_pixel_format_converter] ERROR");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        pred_format = FMT_PALETTE8;
        mask_red    = RED_MASK_RESET;
        mask_green  = GREEN_MASK_RESET;
        mask_blue   = BLUE_MASK_RESET;
        mask_alpha  = ALPHA_MASK_RESET;
        key_value   = '0;
        last_loaded = '0;
        foreach (palette_set[i])
        begin
            palette_set[i] = 1'b0;
            palette_mem[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_palette_load();
        test_backpressure();
        test_random_streams();

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("[bmp_pixel_format_converter] OK");
        end
        else
        begin
            $display("[bmp_pixel_format_converter] ERROR");
        end
        $finish;
    end

endmodule
